// File: rtl/core/arlm_pkg.sv
// ----------------------------------------------------------------------------
// arlm_pkg: shared types and constants of the lifetime matcher
// Item and result layouts, the command passed from front to back,
// back-end states, status codes and a small priority encoder.
// ----------------------------------------------------------------------------
package arlm_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [62:0] SAT63 = {63{1'b1}};

  // Result status codes.
  localparam logic [1:0] ST_MATCHED    = 2'd0;
  localparam logic [1:0] ST_UNRELEASED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [63:0] operator_id;
    logic [63:0] mem_address;
    logic [31:0] device_id;
    logic [63:0] signed_size;
    logic [63:0] event_time;
    logic [63:0] total_allocated;
    logic [63:0] total_reserved;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_operator;
    logic [31:0] out_device;
    logic [62:0] alloc_size;
    logic [63:0] alloc_time;
    logic [63:0] alloc_total_allocated;
    logic [63:0] alloc_total_reserved;
    logic [63:0] release_time;
    logic [63:0] release_total_allocated;
    logic [63:0] release_total_reserved;
    logic [62:0] lifetime;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_RELEASE,
    CMD_DRAIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] op;
    logic [63:0] addr;
    logic [31:0] dev;
    logic [62:0] size;
    logic [63:0] ev_time;
    logic [63:0] tot_alloc;
    logic [63:0] tot_resv;
  } cmd_t;

  // Handshake of the command queue toward the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_ACT,
    S_SCAN,
    S_EMIT
  } back_state_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [IDX_W-1:0] lowest_index(input logic [TABLE_DEPTH-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/arlm_front.sv
// ----------------------------------------------------------------------------
// arlm_front: input acceptance and classification
// Sorts each accepted item into allocation, release or drain, drops zero-size
// events, and holds commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module arlm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  arlm_pkg::in_item_t item,
  output arlm_pkg::cmd_chan_t chan,
  input  logic              cmd_pop
);
  import arlm_pkg::*;

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  logic       take;
  cmd_t       cmd_new;

  assign full   = (count == 2'd2);
  assign accept = push && !full;

  // Classify the incoming transaction.
  always_comb begin
    cmd_new.op        = item.operator_id;
    cmd_new.addr      = item.mem_address;
    cmd_new.dev       = item.device_id;
    cmd_new.size      = item.signed_size[62:0];
    cmd_new.ev_time   = item.event_time;
    cmd_new.tot_alloc = item.total_allocated;
    cmd_new.tot_resv  = item.total_reserved;
    if (item.mode) begin
      cmd_new.kind = CMD_DRAIN;
    end else if (item.signed_size[63]) begin
      cmd_new.kind = CMD_RELEASE;
    end else begin
      cmd_new.kind = CMD_ALLOC;
    end
  end

  assign keep = accept && (item.mode || (item.signed_size != 64'd0));
  assign take = cmd_pop && (count != 2'd0);

  assign chan.valid = (count != 2'd0);
  assign chan.cmd   = queue[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(keep) - 2'(take);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (keep) begin
      queue[wr_ptr] <= cmd_new;
    end
  end

endmodule

// File: rtl/core/arlm_back.sv
// ----------------------------------------------------------------------------
// arlm_back: allocation table and command execution
// Holds the entry table, matches keys in parallel, updates entries, walks the
// table for drains and drives the result register.
// ----------------------------------------------------------------------------
module arlm_back (
  input  logic                clk,
  input  logic                rst,
  input  arlm_pkg::cmd_chan_t chan,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output arlm_pkg::result_t   result
);
  import arlm_pkg::*;

  // Entry table.
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [63:0] entry_operator        [TABLE_DEPTH];
  logic [63:0] entry_address         [TABLE_DEPTH];
  logic [31:0] entry_device          [TABLE_DEPTH];
  logic [62:0] entry_size            [TABLE_DEPTH];
  logic [63:0] entry_alloc_time      [TABLE_DEPTH];
  logic [63:0] entry_alloc_allocated [TABLE_DEPTH];
  logic [63:0] entry_alloc_reserved  [TABLE_DEPTH];
  logic [63:0] entry_age             [TABLE_DEPTH];
  logic [63:0] age_counter;

  back_state_t state, state_next;
  cmd_t        cmd;
  logic [TABLE_DEPTH-1:0] hit_vec;

  // Drain walk registers.
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] best_idx;
  logic [63:0]      best_age;
  logic             best_found;
  logic [CNT_W-1:0] drain_cnt;

  logic    out_valid;
  result_t out_data;

  // Combinational controls.
  logic             ld_ok;
  logic             cmd_take;
  logic             out_load;
  result_t          out_next;
  logic             wr_pay;
  logic             wr_key;
  logic [IDX_W-1:0] wr_idx;
  logic             clr_v;
  logic [IDX_W-1:0] clr_idx;
  logic             age_inc;
  logic             age_clr;
  logic             scan_start;
  logic             scan_step;
  logic             cand;
  logic             emitted;

  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic             tbl_full;
  logic [63:0]      span_diff;
  logic [62:0]      span_life;
  logic [TABLE_DEPTH-1:0] rest;
  logic             drain_last;

  assign empty  = !out_valid;
  assign result = out_data;
  assign ld_ok  = !out_valid || pop;
  assign cmd_pop = cmd_take;

  assign hit_any  = |hit_vec;
  assign hit_idx  = lowest_index(hit_vec);
  assign free_idx = lowest_index(~entry_valid);
  assign tbl_full = &entry_valid;

  // Lifetime of a matched release, saturated and floored at zero.
  assign span_diff = cmd.ev_time - entry_alloc_time[hit_idx];
  always_comb begin
    if (cmd.ev_time < entry_alloc_time[hit_idx]) begin
      span_life = '0;
    end else if (span_diff[63]) begin
      span_life = SAT63;
    end else begin
      span_life = span_diff[62:0];
    end
  end

  // Drain candidate at the scan index, and end-of-drain check.
  assign cand = entry_valid[scan_idx] &&
                (!best_found || (entry_age[scan_idx] < best_age));
  assign rest = entry_valid & ~(TABLE_DEPTH'(1) << best_idx);
  assign drain_last = (rest == '0) || (drain_cnt == CNT_W'(MAX_RESULTS - 1));

  // Next state and control.
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    wr_pay     = 1'b0;
    wr_key     = 1'b0;
    wr_idx     = hit_idx;
    clr_v      = 1'b0;
    clr_idx    = hit_idx;
    age_inc    = 1'b0;
    age_clr    = 1'b0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    emitted    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (chan.valid) begin
          cmd_take = 1'b1;
          if (chan.cmd.kind == CMD_DRAIN) begin
            scan_start = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        state_next = S_ACT;
      end
      S_ACT: begin
        if (cmd.kind == CMD_ALLOC) begin
          if (hit_any) begin
            wr_pay     = 1'b1;
            state_next = S_IDLE;
          end else if (!tbl_full) begin
            wr_pay     = 1'b1;
            wr_key     = 1'b1;
            wr_idx     = free_idx;
            age_inc    = 1'b1;
            state_next = S_IDLE;
          end else if (ld_ok) begin
            out_load                       = 1'b1;
            out_next.out_operator          = cmd.op;
            out_next.out_device            = cmd.dev;
            out_next.alloc_size            = cmd.size;
            out_next.alloc_time            = cmd.ev_time;
            out_next.alloc_total_allocated = cmd.tot_alloc;
            out_next.alloc_total_reserved  = cmd.tot_resv;
            out_next.status                = ST_OVERFLOW;
            out_next.last                  = 1'b1;
            state_next                     = S_IDLE;
          end
        end else if (!hit_any) begin
          state_next = S_IDLE;
        end else if (ld_ok) begin
          out_load                         = 1'b1;
          clr_v                            = 1'b1;
          out_next.out_operator            = entry_operator[hit_idx];
          out_next.out_device              = entry_device[hit_idx];
          out_next.alloc_size              = entry_size[hit_idx];
          out_next.alloc_time              = entry_alloc_time[hit_idx];
          out_next.alloc_total_allocated   = entry_alloc_allocated[hit_idx];
          out_next.alloc_total_reserved    = entry_alloc_reserved[hit_idx];
          out_next.release_time            = cmd.ev_time;
          out_next.release_total_allocated = cmd.tot_alloc;
          out_next.release_total_reserved  = cmd.tot_resv;
          out_next.lifetime                = span_life;
          out_next.status                  = ST_MATCHED;
          out_next.last                    = 1'b1;
          state_next                       = S_IDLE;
        end
      end
      S_SCAN: begin
        scan_step = 1'b1;
        if (scan_idx == IDX_W'(TABLE_DEPTH - 1)) begin
          if (best_found || cand) begin
            state_next = S_EMIT;
          end else begin
            age_clr    = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (ld_ok) begin
          out_load                       = 1'b1;
          clr_v                          = 1'b1;
          clr_idx                        = best_idx;
          emitted                        = 1'b1;
          out_next.out_operator          = entry_operator[best_idx];
          out_next.out_device            = entry_device[best_idx];
          out_next.alloc_size            = entry_size[best_idx];
          out_next.alloc_time            = entry_alloc_time[best_idx];
          out_next.alloc_total_allocated = entry_alloc_allocated[best_idx];
          out_next.alloc_total_reserved  = entry_alloc_reserved[best_idx];
          out_next.status                = ST_UNRELEASED;
          out_next.last                  = drain_last;
          if (drain_last) begin
            age_clr    = (rest == '0);
            state_next = S_IDLE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, valid bits, age counter, drain walk and result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      age_counter <= 64'd0;
      out_valid   <= 1'b0;
      scan_idx    <= '0;
      best_found  <= 1'b0;
      drain_cnt   <= '0;
    end else begin
      state <= state_next;
      if (wr_key) begin
        entry_valid[wr_idx] <= 1'b1;
      end
      if (clr_v) begin
        entry_valid[clr_idx] <= 1'b0;
      end
      if (age_clr) begin
        age_counter <= 64'd0;
      end else if (age_inc) begin
        age_counter <= age_counter + 64'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (scan_start) begin
        drain_cnt <= '0;
      end else if (emitted) begin
        drain_cnt <= drain_cnt + CNT_W'(1);
      end
      if (scan_start || emitted) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else if (scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
        if (cand) begin
          best_found <= 1'b1;
        end
      end
    end
  end

  // Payload registers: command, match vector, best entry, result data.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd <= chan.cmd;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_vec[i] <= entry_valid[i] && (entry_operator[i] == cmd.op) &&
                    (entry_address[i] == cmd.addr) && (entry_device[i] == cmd.dev);
    end
    if (scan_step && cand) begin
      best_idx <= scan_idx;
      best_age <= entry_age[scan_idx];
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Table writes.
  always_ff @(posedge clk) begin
    if (wr_key) begin
      entry_operator[wr_idx] <= cmd.op;
      entry_address[wr_idx]  <= cmd.addr;
      entry_device[wr_idx]   <= cmd.dev;
      entry_age[wr_idx]      <= age_counter;
    end
    if (wr_pay) begin
      entry_size[wr_idx]            <= cmd.size;
      entry_alloc_time[wr_idx]      <= cmd.ev_time;
      entry_alloc_allocated[wr_idx] <= cmd.tot_alloc;
      entry_alloc_reserved[wr_idx]  <= cmd.tot_resv;
    end
  end

endmodule

// File: rtl/core/alloc_release_lifetime_matcher_top.sv
// ----------------------------------------------------------------------------
// alloc_release_lifetime_matcher_top: memory allocation lifetime matcher
// Pairs allocation and release events by key and reports lifecycles.
// ----------------------------------------------------------------------------
// Input side: an event or drain transaction is taken when push is high and
// full is low. Zero-size events are taken and dropped. Two commands can wait
// between the classifier and the table engine.
// Result side: while empty is low the oldest result is on result; pop takes
// it. One result register holds it, so a stalled receiver holds the engine
// on the next result-producing step while input keeps filling the queue.
// Flow: an event waits in the queue, then the engine takes it, runs the
// parallel key compare and then the update, and takes no new command until
// the update is done. A matched release or an overflow lands in the result
// register at the end of the update, once the result register is free. A
// drain walks the table one entry a cycle for each result, and walks an
// empty table once.
// Reset (rst, synchronous): all entries invalid, age counter zero, queue and
// result register empty.
// ----------------------------------------------------------------------------
module alloc_release_lifetime_matcher_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  arlm_pkg::in_item_t item,
  output logic               empty,
  input  logic               pop,
  output arlm_pkg::result_t  result
);
  import arlm_pkg::*;

  cmd_chan_t chan;
  logic      cmd_pop;

  arlm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .chan    (chan),
    .cmd_pop (cmd_pop)
  );

  arlm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .chan    (chan),
    .cmd_pop (cmd_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the allocation/release lifetime matcher
// Directed and random event streams are checked against a cycle-free
// predictor of the key table. Sender idling and receiver stalling are varied
// across phases, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import arlm_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  in_item_t item = '0;
  logic     empty;
  logic     pop = 1'b0;
  result_t  result;

  alloc_release_lifetime_matcher_top u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always #4 clk = ~clk;

  // Predictor copy of the key table.
  logic        tbl_valid [TABLE_DEPTH];
  logic [63:0] tbl_op [TABLE_DEPTH];
  logic [63:0] tbl_addr [TABLE_DEPTH];
  logic [31:0] tbl_dev [TABLE_DEPTH];
  logic [62:0] tbl_size [TABLE_DEPTH];
  logic [63:0] tbl_time [TABLE_DEPTH];
  logic [63:0] tbl_talloc [TABLE_DEPTH];
  logic [63:0] tbl_tresv [TABLE_DEPTH];
  logic [63:0] tbl_age [TABLE_DEPTH];
  logic [63:0] age_next;

  result_t     lifecycle_q[$];
  int          err_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;
  int          hold_cycles = 0;
  int          cycle_count = 0;
  logic [63:0] clock_now = 64'd1000;
  logic [63:0] op_pool [8];
  logic [63:0] addr_pool [8];
  logic [31:0] dev_pool [4];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic result_t lifecycle_of(int i);
    result_t r;
    r = '0;
    r.out_operator = tbl_op[i];
    r.out_device = tbl_dev[i];
    r.alloc_size = tbl_size[i];
    r.alloc_time = tbl_time[i];
    r.alloc_total_allocated = tbl_talloc[i];
    r.alloc_total_reserved = tbl_tresv[i];
    return r;
  endfunction

  // Work out the lifecycles that one accepted transaction causes.
  task automatic predict_lifecycles(in_item_t it);
    int hit;
    int slot;
    int best;
    int n;
    result_t r;
    logic [63:0] d;
    hit = -1;
    slot = -1;
    n = 0;
    if (it.mode) begin
      while (n < MAX_RESULTS) begin
        best = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (tbl_valid[i] && (best < 0 || tbl_age[i] < tbl_age[best])) best = i;
        if (best < 0) break;
        r = lifecycle_of(best);
        r.status = ST_UNRELEASED;
        lifecycle_q.push_back(r);
        tbl_valid[best] = 1'b0;
        n++;
      end
      best = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) if (tbl_valid[i]) best = 1;
      if (best == 0) age_next = '0;
    end else if (it.signed_size != 0) begin
      for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        if (tbl_valid[i] && tbl_op[i] == it.operator_id && tbl_addr[i] == it.mem_address
            && tbl_dev[i] == it.device_id) hit = i;
      if (!it.signed_size[63]) begin
        slot = hit;
        if (slot < 0) begin
          for (int i = TABLE_DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
          if (slot < 0) begin
            r = '0;
            r.out_operator = it.operator_id;
            r.out_device = it.device_id;
            r.alloc_size = it.signed_size[62:0];
            r.alloc_time = it.event_time;
            r.alloc_total_allocated = it.total_allocated;
            r.alloc_total_reserved = it.total_reserved;
            r.status = ST_OVERFLOW;
            lifecycle_q.push_back(r);
            n = 1;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_op[slot] = it.operator_id;
            tbl_addr[slot] = it.mem_address;
            tbl_dev[slot] = it.device_id;
            tbl_age[slot] = age_next;
            age_next++;
          end
        end
        if (slot >= 0) begin
          tbl_size[slot] = it.signed_size[62:0];
          tbl_time[slot] = it.event_time;
          tbl_talloc[slot] = it.total_allocated;
          tbl_tresv[slot] = it.total_reserved;
        end
      end else if (hit >= 0) begin
        r = lifecycle_of(hit);
        r.release_time = it.event_time;
        r.release_total_allocated = it.total_allocated;
        r.release_total_reserved = it.total_reserved;
        // Lifetime saturates, and is zero for a release before its allocation.
        if (it.event_time < tbl_time[hit]) d = '0;
        else d = it.event_time - tbl_time[hit];
        r.lifetime = d[63] ? SAT63 : d[62:0];
        r.status = ST_MATCHED;
        lifecycle_q.push_back(r);
        tbl_valid[hit] = 1'b0;
        n = 1;
      end
    end
    if (n > 0) lifecycle_q[lifecycle_q.size() - 1].last = 1'b1;
  endtask

  // Offer one transaction, idling first at the current rate.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predict_lifecycles(it);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (lifecycle_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t mem_event(logic [63:0] op, logic [63:0] addr, logic [31:0] dev,
                                         logic [63:0] size, logic [63:0] t);
    in_item_t it;
    it = '0;
    it.operator_id = op;
    it.mem_address = addr;
    it.device_id = dev;
    it.signed_size = size;
    it.event_time = t;
    it.total_allocated = rand64();
    it.total_reserved = rand64();
    return it;
  endfunction

  function automatic in_item_t drain_item();
    in_item_t it;
    it = mem_event(rand64(), rand64(), $urandom, rand64(), rand64());
    it.mode = 1'b1;
    return it;
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, actual %h", name, exp, act);
      err_count++;
    end
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (lifecycle_q.size() == 0) begin
        $error("unexpected result transaction, operator %h", result.out_operator);
        err_count++;
      end else begin
        e = lifecycle_q.pop_front();
        check_field("out_operator", e.out_operator, result.out_operator);
        check_field("out_device", e.out_device, result.out_device);
        check_field("alloc_size", e.alloc_size, result.alloc_size);
        check_field("alloc_time", e.alloc_time, result.alloc_time);
        check_field("alloc_total_allocated", e.alloc_total_allocated,
                    result.alloc_total_allocated);
        check_field("alloc_total_reserved", e.alloc_total_reserved,
                    result.alloc_total_reserved);
        check_field("release_time", e.release_time, result.release_time);
        check_field("release_total_allocated", e.release_total_allocated,
                    result.release_total_allocated);
        check_field("release_total_reserved", e.release_total_reserved,
                    result.release_total_reserved);
        check_field("lifetime", e.lifetime, result.lifetime);
        check_field("status", e.status, result.status);
        check_field("last", e.last, result.last);
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Extremes, saturation, early release, misses, zero size and overwrite.
  task automatic test_directed();
    logic [63:0] ones;
    in_item_t it;
    ones = '1;
    it = mem_event(ones, ones, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    it.total_allocated = ones;
    it.total_reserved = ones;
    send_item(it);
    send_item(mem_event(ones, ones, 32'hFFFF_FFFF, ones, ones));
    send_item(mem_event(64'd0, 64'd0, 32'd0, 64'd1, 64'd100));
    send_item(mem_event(64'd0, 64'd0, 32'd0, 64'h8000_0000_0000_0000, 64'd50));
    send_item(mem_event(64'd5, 64'd6, 32'd7, 64'd0, 64'd200));
    send_item(mem_event(64'd5, 64'd6, 32'd7, -64'sd3, 64'd210));
    send_item(mem_event(64'd5, 64'd6, 32'd7, 64'd10, 64'd220));
    send_item(mem_event(64'd9, 64'd6, 32'd7, 64'd20, 64'd230));
    // Reallocation of a held key overwrites it but keeps its age.
    send_item(mem_event(64'd5, 64'd6, 32'd7, 64'd30, 64'd240));
    send_item(mem_event(64'd5, 64'd6, 32'd8, -64'sd1, 64'd250));
    send_item(drain_item());
    send_item(drain_item());
    send_item(mem_event(64'd9, 64'd6, 32'd7, -64'sd1, 64'd260));
  endtask

  // One more allocation than the table holds, then a full drain.
  task automatic test_overflow();
    for (int i = 0; i <= TABLE_DEPTH; i++)
      send_item(mem_event(rand64(), rand64(), $urandom, {$urandom_range(1000, 1), 32'd0},
                          clock_now + 64'(i)));
    send_item(drain_item());
  endtask

  // Receiver holds off while overflow results pile up behind it.
  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < TABLE_DEPTH + 24; i++)
      send_item(mem_event(rand64(), rand64(), $urandom, rand64() >> 2, rand64()));
    send_item(drain_item());
  endtask

  function automatic in_item_t random_item();
    int pick;
    int slot;
    in_item_t it;
    logic [63:0] t;
    pick = $urandom_range(99);
    clock_now = clock_now + $urandom_range(5000);
    t = ($urandom_range(9) == 0) ? rand64() : clock_now;
    it = mem_event(op_pool[$urandom_range(7)], addr_pool[$urandom_range(7)],
                   dev_pool[$urandom_range(3)], rand64() >> 1, t);
    if (pick < 40) begin
      if (it.signed_size == 0) it.signed_size = 64'd1;
    end else if (pick < 80) begin
      // Release a held entry where there is one.
      slot = $urandom_range(TABLE_DEPTH - 1);
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (tbl_valid[(slot + i) % TABLE_DEPTH]) begin
          slot = (slot + i) % TABLE_DEPTH;
          break;
        end
      if (tbl_valid[slot]) begin
        it.operator_id = tbl_op[slot];
        it.mem_address = tbl_addr[slot];
        it.device_id = tbl_dev[slot];
      end
      it.signed_size = 64'h8000_0000_0000_0000 | rand64();
    end else if (pick < 87) begin
      it = mem_event(rand64(), rand64(), $urandom, rand64(), t);
    end else if (pick < 92) begin
      it.signed_size = '0;
    end else if (pick < 96) begin
      it = drain_item();
    end
    return it;
  endfunction

  task automatic test_random(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < 8; i++) begin
      op_pool[i] = rand64();
      addr_pool[i] = rand64();
    end
    for (int i = 0; i < 4; i++) dev_pool[i] = $urandom;
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
    age_next = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random(0, 0, 100);
    test_random(67, 0, 100);
    test_random(0, 67, 100);
    test_random(13, 13, 100);
    stop_sending();
    wait_drained();
    repeat (TABLE_DEPTH * (TABLE_DEPTH + 1) + 50) @(posedge clk);
    $display("Covered %0d input transactions and %0d lifecycle results across",
             items_sent, results_seen);
    $display("directed, overflow, back-pressure and four random idling phases.");
    if (err_count == 0 && lifecycle_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: alloc_release_lifetime_matcher_top.f
rtl/core/arlm_pkg.sv
rtl/core/arlm_front.sv
rtl/core/arlm_back.sv
rtl/core/alloc_release_lifetime_matcher_top.sv
test/tb_top.sv
